[rtl/bqf_pkg.sv]
`default_nettype none

package bqf_pkg;

  // fixed formats: samples Q.0, coefficients Q2.16, accumulator Q24.16
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int ACC_BITS       = 40;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int STEP_BITS      = 3;

  // register indexes on the config port
  localparam logic [CFG_ADDR_BITS-1:0] REG_B0   = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_B1   = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_B2   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_A2   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FORM = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_ROUND,
    ST_FEED2,
    ST_DRAIN2,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_sel_e;

  typedef enum logic [2:0] {
    OP_X,
    OP_D1,
    OP_D2,
    OP_YD1,
    OP_YD2,
    OP_Y
  } opnd_sel_e;

  typedef enum logic [1:0] {
    INIT_ACC,
    INIT_ZERO,
    INIT_D1,
    INIT_D2
  } init_e;

  typedef enum logic [1:0] {
    STORE_NONE,
    STORE_D1,
    STORE_D2
  } store_e;

  // one multiply-accumulate step
  typedef struct packed {
    coef_sel_e coef;
    opnd_sel_e opnd;
    logic      sub;
    init_e     init;
    store_e    store;
    logic      last;
  } uop_t;

  // step table: form 0 is one five-product pass, form 1 is a one-product
  // pass for the output and a four-product pass for the two accumulators
  function uop_t bqf_uop(logic form, logic pass2, logic [STEP_BITS-1:0] step);
    uop_t u;
    u.coef  = COEF_B0;
    u.opnd  = OP_X;
    u.sub   = 1'b0;
    u.init  = INIT_ACC;
    u.store = STORE_NONE;
    u.last  = 1'b0;
    if (!form) begin
      case (step)
        3'd0: u.init = INIT_ZERO;
        3'd1: begin
          u.coef = COEF_B1;
          u.opnd = OP_D1;
        end
        3'd2: begin
          u.coef = COEF_B2;
          u.opnd = OP_D2;
        end
        3'd3: begin
          u.coef = COEF_A1;
          u.opnd = OP_YD1;
          u.sub  = 1'b1;
        end
        default: begin
          u.coef = COEF_A2;
          u.opnd = OP_YD2;
          u.sub  = 1'b1;
          u.last = 1'b1;
        end
      endcase
    end else if (!pass2) begin
      u.init = INIT_D1;
      u.last = 1'b1;
    end else begin
      case (step)
        3'd0: begin
          u.coef = COEF_B1;
          u.init = INIT_D2;
        end
        3'd1: begin
          u.coef  = COEF_A1;
          u.opnd  = OP_Y;
          u.sub   = 1'b1;
          u.store = STORE_D1;
        end
        3'd2: begin
          u.coef = COEF_B2;
          u.init = INIT_ZERO;
        end
        default: begin
          u.coef  = COEF_A2;
          u.opnd  = OP_Y;
          u.sub   = 1'b1;
          u.store = STORE_D2;
          u.last  = 1'b1;
        end
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

[rtl/biquad_iir_filter.sv]
`default_nettype none
// Second-order IIR section on signed 16-bit samples, coefficients in
// signed Q2.16. Input samples arrive on a valid/ready channel
// (in_valid_i, in_ready_o, sample_in_i); each yields one transaction on the
// output channel (out_valid_o, out_ready_i, sample_out_o, clipped_o).
// Coefficients and the form select are written through cfg_we_i,
// cfg_addr_i, cfg_wdata_i; the user must write them only while the
// filter is idle, which the block itself does not enforce. Writing the
// form register (any value) clears the filter history, coefficient
// writes do not. Indexes past the form register are ignored. One signed
// 18x16 multiplier and a 40-bit accumulator are shared over all products
// under a small sequencer, with a register after the multiplier. Direct
// form I steps through accept, five products, drain, round, write back;
// transposed form II through accept, one product, drain, round, four
// products, drain, write back. Those sequencer steps set the rate;
// in_ready_o is high only while idle. out_valid_o rises at the edge that
// leaves the write-back state, once the output register is free.
// The result sits in an output register: if the receiver stalls, the
// next sample is still taken and processed, and its write-back waits
// until the pending result is taken.
// Reset restores unity gain in direct form I with all history cleared.

module biquad_iir_filter
  import bqf_pkg::*;
(
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire        [CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  wire        [COEF_BITS-1:0]       cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]    sample_out_o,
  output logic                             clipped_o
);

  localparam int RQ_BITS = ACC_BITS + 1 - COEF_FRAC_BITS;
  localparam logic signed [ACC_BITS:0] RND_HALF =
    (ACC_BITS + 1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RQ_BITS-1:0] SAT_HI =
    RQ_BITS'((64'sd1 << (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RQ_BITS-1:0] SAT_LO = -SAT_HI - RQ_BITS'(1);
  localparam logic signed [SAMPLE_BITS-1:0] OUT_HI = SAT_HI[SAMPLE_BITS-1:0];
  localparam logic signed [SAMPLE_BITS-1:0] OUT_LO = SAT_LO[SAMPLE_BITS-1:0];

  // configuration
  logic signed [COEF_BITS-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic                        form_q;

  // filter history
  logic signed [ACC_BITS-1:0]    d1_q, d2_q;
  logic signed [SAMPLE_BITS-1:0] yd1_q, yd2_q;

  // sequencer
  state_e                 state_q, state_d;
  logic [STEP_BITS-1:0]   step_q, step_d;
  uop_t                   uop;
  logic                   issue, y_load, done;

  // datapath
  logic signed [SAMPLE_BITS-1:0] x_q, y_q;
  logic                          clip_q;
  logic signed [COEF_BITS-1:0]   coef_mux;
  logic signed [SAMPLE_BITS-1:0] opnd_mux;
  logic signed [PROD_BITS-1:0]   prod_d, prod_q;
  uop_t                          tag_q;
  logic                          tag_vld_q;
  logic signed [ACC_BITS-1:0]    acc_q, acc_base, acc_next, prod_ext;

  // rounding and saturation
  logic signed [ACC_BITS:0]      rnd_t;
  logic signed [RQ_BITS-1:0]     rnd_v;
  logic                          rnd_clip;
  logic signed [SAMPLE_BITS-1:0] rnd_y;

  // output register
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_clip_q;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign uop = bqf_uop(form_q, state_q == ST_FEED2, step_q);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    issue      = 1'b0;
    y_load     = 1'b0;
    done       = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_FEED;
          step_d  = '0;
        end
      end
      ST_FEED: begin
        issue  = 1'b1;
        step_d = step_q + 3'd1;
        if (uop.last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_ROUND;
      ST_ROUND: begin
        y_load = 1'b1;
        if (form_q) begin
          state_d = ST_FEED2;
          step_d  = '0;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FEED2: begin
        issue  = 1'b1;
        step_d = step_q + 3'd1;
        if (uop.last) state_d = ST_DRAIN2;
      end
      ST_DRAIN2: state_d = ST_DONE;
      ST_DONE: begin
        // wait for a free output register
        if (!out_vld_q || out_ready_i) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    case (uop.coef)
      COEF_B0: coef_mux = b0_q;
      COEF_B1: coef_mux = b1_q;
      COEF_B2: coef_mux = b2_q;
      COEF_A1: coef_mux = a1_q;
      default: coef_mux = a2_q;
    endcase
    case (uop.opnd)
      OP_X:    opnd_mux = x_q;
      OP_D1:   opnd_mux = d1_q[SAMPLE_BITS-1:0];
      OP_D2:   opnd_mux = d2_q[SAMPLE_BITS-1:0];
      OP_YD1:  opnd_mux = yd1_q;
      OP_YD2:  opnd_mux = yd2_q;
      default: opnd_mux = y_q;
    endcase
  end

  assign prod_d = coef_mux * opnd_mux;

  // ---------------- accumulator ----------------
  assign prod_ext = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

  always_comb begin
    case (tag_q.init)
      INIT_ZERO: acc_base = '0;
      INIT_D1:   acc_base = d1_q;
      INIT_D2:   acc_base = d2_q;
      default:   acc_base = acc_q;
    endcase
    acc_next = tag_q.sub ? acc_base - prod_ext : acc_base + prod_ext;
  end

  // round half-up from Q.16, then saturate
  assign rnd_t    = $signed({acc_q[ACC_BITS-1], acc_q}) + RND_HALF;
  assign rnd_v    = rnd_t[ACC_BITS:COEF_FRAC_BITS];
  assign rnd_clip = (rnd_v > SAT_HI) || (rnd_v < SAT_LO);
  assign rnd_y    = (rnd_v > SAT_HI) ? OUT_HI :
                    (rnd_v < SAT_LO) ? OUT_LO : rnd_v[SAMPLE_BITS-1:0];

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) x_q <= sample_in_i;
    prod_q <= prod_d;
    tag_q  <= uop;
    if (tag_vld_q) acc_q <= acc_next;
    if (y_load) begin
      y_q    <= rnd_y;
      clip_q <= rnd_clip;
    end
    if (done) begin
      out_sample_q <= y_q;
      out_clip_q   <= clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      tag_vld_q <= issue;
      if (done) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // ---------------- history and configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= COEF_BITS'(64'sd1 << COEF_FRAC_BITS);
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      form_q <= 1'b0;
      d1_q   <= '0;
      d2_q   <= '0;
      yd1_q  <= '0;
      yd2_q  <= '0;
    end else begin
      // transposed form: accumulators written from the mac pass
      if (tag_vld_q && tag_q.store == STORE_D1) d1_q <= acc_next;
      if (tag_vld_q && tag_q.store == STORE_D2) d2_q <= acc_next;
      // direct form I: shift the sample and output lines
      if (done && !form_q) begin
        d2_q  <= d1_q;
        d1_q  <= {{(ACC_BITS-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
        yd2_q <= yd1_q;
        yd1_q <= y_q;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_B0: b0_q <= cfg_wdata_i;
          REG_B1: b1_q <= cfg_wdata_i;
          REG_B2: b2_q <= cfg_wdata_i;
          REG_A1: a1_q <= cfg_wdata_i;
          REG_A2: a2_q <= cfg_wdata_i;
          REG_FORM: begin
            form_q <= cfg_wdata_i[0];
            d1_q   <= '0;
            d2_q   <= '0;
            yd1_q  <= '0;
            yd2_q  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

  // ---------------- assertions ----------------
  a_form_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_addr_i == REG_FORM
    |=> d1_q == '0 && d2_q == '0 && yd1_q == '0 && yd2_q == '0)
    else $error("form write did not clear history");

  a_clip_is_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> sample_out_o == OUT_HI || sample_out_o == OUT_LO)
    else $error("clipped result not at a rail");

  a_mac_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_vld_q |-> state_q == ST_FEED || state_q == ST_DRAIN ||
                  state_q == ST_FEED2 || state_q == ST_DRAIN2)
    else $error("accumulate outside a mac pass");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside write-back");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_FEED && !in_ready_o)
    else $error("accepted sample did not start a pass");

endmodule

`default_nettype wire

[dv/bqf_test_pkg.sv]
`timescale 1ns / 100ps

package bqf_test_pkg;

  import bqf_pkg::*;

  // values of the form select register
  localparam logic FORM_DF1  = 1'b0;
  localparam logic FORM_TDF2 = 1'b1;

  // one output transaction
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
  } filtered_t;

endpackage

[dv/bqf_checker.sv]
`timescale 1ns / 100ps

module bqf_checker
  import bqf_pkg::*;
  import bqf_test_pkg::*;
(
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire        [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  wire        [COEF_BITS-1:0]     cfg_wdata_i,
  input  wire                           in_valid_i,
  input  wire                           in_ready_i,
  input  wire signed [SAMPLE_BITS-1:0]   sample_in_i,
  input  wire                           out_valid_i,
  input  wire                           out_ready_i,
  input  wire signed [SAMPLE_BITS-1:0]   sample_out_i,
  input  wire                           clipped_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic signed [COEF_BITS-1:0]   b0, b1, b2, a1, a2;
  logic                          form;
  // direct form I: past inputs; transposed form II: the two accumulators
  longint                        hist_x1, hist_x2;
  logic signed [SAMPLE_BITS-1:0] hist_y1, hist_y2;
  filtered_t                     filtered_q[$];
  filtered_t                     want;
  int                            fails;

  function longint wrap_acc(input longint v);
    logic signed [ACC_BITS-1:0] t;
    t = v[ACC_BITS-1:0];
    return longint'(t);
  endfunction

  // half-up rounding out of Q.16, then saturation to the sample range
  function filtered_t round_sat(input longint acc);
    longint    q;
    filtered_t r;
    q = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    r.clipped = 1'b0;
    if (q > SAT_HI) begin
      q = SAT_HI;
      r.clipped = 1'b1;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
      r.clipped = 1'b1;
    end
    r.sample = q[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function filtered_t filter_step(input logic signed [SAMPLE_BITS-1:0] x);
    longint                        xs, ys, acc;
    logic signed [SAMPLE_BITS-1:0] y;
    filtered_t                     r;
    xs = longint'(x);
    if (form == FORM_DF1) begin
      acc = wrap_acc(longint'(b0) * xs + longint'(b1) * hist_x1 + longint'(b2) * hist_x2
                     - longint'(a1) * longint'(hist_y1) - longint'(a2) * longint'(hist_y2));
      r = round_sat(acc);
      y = r.sample;
      hist_x2 = hist_x1;
      hist_x1 = xs;
      hist_y2 = hist_y1;
      hist_y1 = y;
    end else begin
      acc = wrap_acc(longint'(b0) * xs + hist_x1);
      r = round_sat(acc);
      y = r.sample;
      ys = longint'(y);
      hist_x1 = wrap_acc(longint'(b1) * xs - longint'(a1) * ys + hist_x2);
      hist_x2 = wrap_acc(longint'(b2) * xs - longint'(a2) * ys);
    end
    return r;
  endfunction

  task clear_history;
    hist_x1 = 0;
    hist_x2 = 0;
    hist_y1 = '0;
    hist_y2 = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0 = '0;
      b0[COEF_FRAC_BITS] = 1'b1;
      b1 = '0;
      b2 = '0;
      a1 = '0;
      a2 = '0;
      form = FORM_DF1;
      clear_history();
      filtered_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output transaction: sample_out %0d clipped %0b",
                 sample_out_i, clipped_i);
          fails++;
        end else begin
          want = filtered_q.pop_front();
          if (sample_out_i !== want.sample) begin
            $error("sample_out expected %0d actual %0d", want.sample, sample_out_i);
            fails++;
          end
          if (clipped_i !== want.clipped) begin
            $error("clipped expected %0b actual %0b", want.clipped, clipped_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_B0: b0 = cfg_wdata_i;
          REG_B1: b1 = cfg_wdata_i;
          REG_B2: b2 = cfg_wdata_i;
          REG_A1: a1 = cfg_wdata_i;
          REG_A2: a2 = cfg_wdata_i;
          REG_FORM: begin
            form = cfg_wdata_i[0];
            clear_history();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        filtered_q.push_back(filter_step(sample_in_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= filtered_q.size();
  end

endmodule

[dv/biquad_iir_filter_test.sv]
`timescale 1ns / 100ps

module biquad_iir_filter_test;

  import bqf_pkg::*;
  import bqf_test_pkg::*;

  localparam int N_BLOCKS      = 12;
  localparam int BLOCK_ITEMS   = 90;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_NS      = 10_000_000;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int COEF_MAX = (1 << (COEF_BITS - 1)) - 1;
  localparam int COEF_MIN = -(1 << (COEF_BITS - 1));
  localparam int UNITY    = 1 << COEF_FRAC_BITS;
  localparam int HALF     = 1 << (COEF_FRAC_BITS - 1);

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LO = REG_FORM + 1'b1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_HI = '1;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_ADDR_BITS-1:0]      cfg_addr;
  logic [COEF_BITS-1:0]          cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;
  int                            fail_count;
  int                            pending;

  // idle percentages for the two sides, changed per phase
  int send_idle_pct = 24;
  int recv_idle_pct = 79;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_reqs = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  biquad_iir_filter u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out),
    .clipped_o    (clipped)
  );

  // watches both channels and the config port, predicts and compares
  bqf_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_i (sample_out),
    .clipped_i    (clipped),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random stalls, plus a long hold-off counted here on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("** biquad_iir_filter: FAILED **");
    $finish;
  end

  // one register write per clock; the caller lowers cfg_we after the last one
  task cfg_write(input logic [CFG_ADDR_BITS-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[COEF_BITS-1:0];
    @(posedge clk);
  endtask

  // offer one sample, with a random gap first, and wait for the transaction
  task send_sample(input logic signed [SAMPLE_BITS-1:0] x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every expected transaction came out
  // and the filter is ready again
  task wait_idle;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !in_ready);
  endtask

  // mostly full-range samples, some near zero, some at the rails
  function logic signed [SAMPLE_BITS-1:0] rand_sample();
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(0, 9);
    r    = $urandom;
    if (pick == 0) begin
      return r[0] ? SAMPLE_MAX : SAMPLE_MIN;
    end else if (pick < 3) begin
      return $signed(r[SAMPLE_BITS-1:0]) >>> 6;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  // gentle keeps taps other than the rail values within +-0.5 so that not every output clips
  function int rand_coef(input bit gentle);
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(0, 7);
    r    = $urandom;
    if (pick == 0) begin
      return COEF_MAX;
    end else if (pick == 1) begin
      return COEF_MIN;
    end else if (gentle) begin
      return $signed(r[COEF_FRAC_BITS-1:0]);
    end
    return $signed(r[COEF_BITS-1:0]);
  endfunction

  initial begin : stimulus
    bit gentle;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    sample_in <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unity gain, direct form I, straight out of reset
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(1);
    send_sample(-1);

    // gain of one half: exact halves round toward plus infinity
    wait_idle();
    cfg_write(REG_B0, HALF);
    cfg_we <= 1'b0;
    send_sample(1);
    send_sample(-1);
    send_sample(3);
    send_sample(-3);

    // near-double gain clips at both rails
    wait_idle();
    cfg_write(REG_B0, COEF_MAX);
    cfg_we <= 1'b0;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(20000);

    // gain of minus two: the most negative sample clips high
    wait_idle();
    cfg_write(REG_B0, COEF_MIN);
    cfg_we <= 1'b0;
    send_sample(SAMPLE_MIN);
    send_sample(12345);

    // every tap at an extreme, direct form I, history cleared
    wait_idle();
    cfg_write(REG_B1, COEF_MIN);
    cfg_write(REG_B2, COEF_MAX);
    cfg_write(REG_A1, COEF_MIN);
    cfg_write(REG_A2, COEF_MAX);
    cfg_write(REG_FORM, FORM_DF1);
    cfg_we <= 1'b0;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(-7);

    // same taps in transposed form II
    wait_idle();
    cfg_write(REG_FORM, FORM_TDF2);
    cfg_we <= 1'b0;
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(100);

    // tap change without a form write keeps the accumulators
    wait_idle();
    cfg_write(REG_B0, UNITY);
    cfg_write(REG_A1, HALF);
    cfg_we <= 1'b0;
    send_sample(0);
    send_sample(-20000);

    // writes to spare indexes change nothing
    wait_idle();
    cfg_write(REG_SPARE_LO, COEF_MAX);
    cfg_write(REG_SPARE_HI, COEF_MIN);
    cfg_we <= 1'b0;
    send_sample(SAMPLE_MAX);

    // random blocks: first sender light / receiver heavy idling,
    // then the other way round, then no idling at all
    for (int blk = 0; blk < N_BLOCKS; blk++) begin
      if (blk < N_BLOCKS / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 79;
      end else if (blk < 2 * N_BLOCKS / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      gentle = ($urandom_range(0, 2) != 0);

      // new taps only while nothing is in flight
      wait_idle();
      cfg_write(REG_B0, rand_coef(gentle));
      cfg_write(REG_B1, rand_coef(gentle));
      cfg_write(REG_B2, rand_coef(gentle));
      cfg_write(REG_A1, rand_coef(gentle));
      cfg_write(REG_A2, rand_coef(gentle));
      // mostly a form write (clears history), random upper data bits
      if ($urandom_range(0, 4) != 0) begin
        cfg_write(REG_FORM, $urandom);
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      end
      cfg_we <= 1'b0;

      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        if (i == BLOCK_ITEMS / 2) begin
          // receiver holds off while samples keep coming: input backs up
          if (blk == N_BLOCKS - 2) begin
            hold_reqs++;
          end
          // sender pauses until every transaction is out
          if (blk == N_BLOCKS / 2) begin
            wait_idle();
          end
        end
        send_sample(rand_sample());
      end
    end

    // drain, then give stray outputs a chance to show up
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** biquad_iir_filter: PASSED **");
    end else begin
      $display("** biquad_iir_filter: FAILED **");
    end
    $finish;
  end

endmodule

[biquad_iir_filter.f]
rtl/bqf_pkg.sv
rtl/biquad_iir_filter.sv
dv/bqf_test_pkg.sv
dv/bqf_checker.sv
dv/biquad_iir_filter_test.sv
